// ===== hdl/lru_key_value_cache_top_assert.svh =====
// assertion macros for the lru key-value cache
// used by the controller and datapath files, no other dependencies
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LKVC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKVC_ASSERT(lbl, clk, rst, prop, msg)
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/lkvc_pkg.sv =====
// shared constants and command struct for the lru key-value cache
// no dependencies
package lkvc_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 16;
  localparam int DATA_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  typedef struct packed {
    logic load_req;
    logic lookup_en;
    logic update_en;
  } cmd_t;

endpackage

// ===== hdl/lru_key_value_cache_top.sv =====
// Fully associative LRU key-value cache. Each request beat (get or put) passes through
// a lookup state for the parallel key compare across all entry cells and the value
// memory read, then an update state for the recency rank update, entry write and result
// register load. The next beat is accepted in the update cycle, so a new request can be
// taken while the previous one finishes; a held result stalls the update state and input.
// Valid bits and occupancy are flip-flops cleared at reset, so no clearing pass.
// capacity_in_use sits at byte address 0 and may be written only while idle.
// top level: apb register, controller and datapath; depends on lkvc_pkg
module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     opcode,
  input  logic signed [DATA_W-1:0] lookup_key,
  input  logic signed [DATA_W-1:0] put_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value
);

  logic [CAP_W-1:0] capacity_in_use;
  cmd_t             cmd;

  assign pready = 1'b1;

  // single register, all byte offsets select it
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      capacity_in_use <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[1:0] == 2'd0 || paddr[1:0] != 2'd0) ?
                  {{(32-CAP_W){1'b0}}, capacity_in_use} : '0;

  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .capacity   (capacity_in_use),
    .opcode     (opcode),
    .lookup_key (lookup_key),
    .put_value  (put_value),
    .hit        (hit),
    .read_value (read_value)
  );

endmodule

// ===== hdl/lkvc_ctrl.sv =====
// request sequencer and result handshake for the lru key-value cache
// depends on lkvc_pkg and the assertion macro header
`include "lru_key_value_cache_top_assert.svh"
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    cmd.lookup_en = 1'b0;
    cmd.update_en = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup_en = 1'b1;
        state_next    = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update_en = 1'b1;
          in_stall      = 1'b0;
          state_next    = in_valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    cmd.load_req = in_valid && !in_stall;
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.update_en) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `LKVC_ASSERT(a_no_overwrite, clk, rst, cmd.update_en |-> !(out_valid && out_stall), "result register overwritten while held")
  `LKVC_ASSERT(a_accept_to_lookup, clk, rst, (in_valid && !in_stall) |=> (state == ST_LOOKUP), "accepted beat did not start a lookup")
  `LKVC_ASSERT(a_lookup_to_update, clk, rst, (state == ST_LOOKUP) |=> (state == ST_UPDATE), "lookup not followed by update")
  `LKVC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (!out_valid && state == ST_IDLE), "reset did not clear control state")

endmodule

// ===== hdl/lkvc_datapath.sv =====
// entry cells, value memory, recency ranks and result register
// depends on lkvc_pkg and the assertion macro header
`include "lru_key_value_cache_top_assert.svh"
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [CAP_W-1:0]         capacity,
  input  logic                     opcode,
  input  logic signed [DATA_W-1:0] lookup_key,
  input  logic signed [DATA_W-1:0] put_value,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value
);

  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  // request register
  logic              req_op;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_val;

  // entry cells
  logic [DATA_W-1:0]    entry_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [IW-1:0]        recency_rank [MAX_ENTRIES];
  logic [CW-1:0]        occupied_count;
  logic [DATA_W-1:0]    value_mem [MAX_ENTRIES];
  logic [DATA_W-1:0]    rd_data;

  // lookup results
  logic [IW-1:0] sel_idx;
  logic [IW-1:0] sel_rank;
  logic          sel_hit;
  logic          sel_insert;
  logic          sel_age_all;

  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] oldest;
  logic [IW-1:0] hit_idx, hit_rank, victim_idx, free_idx, pick_idx;
  logic          any_hit, full;
  logic [CW-1:0] occ_m1;
  logic          do_write;

  assign occ_m1 = occupied_count - CW'(1);

  always_comb begin
    hit_idx    = '0;
    hit_rank   = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_key[i] == req_key);
      oldest[i] = entry_valid[i] && (recency_rank[i] == occ_m1[IW-1:0]);
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | recency_rank[i];
      end
      if (oldest[i]) begin
        victim_idx = victim_idx | IW'(i);
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign any_hit = |match;

  // a capacity of zero acts as one, above the entry count it saturates
  always_comb begin
    full = (occupied_count == CW'(MAX_ENTRIES));
    if (capacity == '0) begin
      full = full || (occupied_count != '0);
    end else begin
      full = full || (CMPW'(occupied_count) >= CMPW'(capacity));
    end
  end

  assign pick_idx = any_hit ? hit_idx : (full ? victim_idx : free_idx);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op  <= opcode;
      req_key <= lookup_key;
      req_val <= put_value;
    end
    if (cmd.lookup_en) begin
      sel_idx     <= pick_idx;
      sel_rank    <= hit_rank;
      sel_hit     <= any_hit;
      sel_insert  <= !any_hit && !full;
      sel_age_all <= !any_hit;
    end
  end

  assign do_write = sel_hit || (req_op == OP_PUT);

  // value memory
  always_ff @(posedge clk) begin
    if (cmd.lookup_en) begin
      rd_data <= value_mem[hit_idx];
    end
    if (cmd.update_en && (req_op == OP_PUT)) begin
      value_mem[sel_idx] <= req_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en && !sel_hit && (req_op == OP_PUT)) begin
      entry_key[sel_idx] <= req_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      occupied_count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (cmd.update_en && do_write) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (sel_idx == IW'(i)) begin
          recency_rank[i] <= '0;
        end else if (entry_valid[i] && (sel_age_all || (recency_rank[i] < sel_rank))) begin
          recency_rank[i] <= recency_rank[i] + IW'(1);
        end
      end
      if (sel_insert) begin
        entry_valid[sel_idx] <= 1'b1;
        occupied_count       <= occupied_count + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      hit        <= sel_hit;
      read_value <= (sel_hit && (req_op == OP_GET)) ? rd_data : MISS_VALUE;
    end
  end

  `LKVC_ASSERT(a_single_match, clk, rst, cmd.lookup_en |-> $onehot0(match), "key present in more than one entry")
  `LKVC_ASSERT(a_occ_bound, clk, rst, occupied_count <= CW'(MAX_ENTRIES), "occupancy above entry count")
  `LKVC_ASSERT(a_occ_matches_valid, clk, rst, $countones(entry_valid) == occupied_count, "occupancy differs from valid entries")

endmodule
